// ===== rtl/sfdcr_pkg.sv =====
`default_nettype none

package sfdcr_pkg;

    // default sizes
    localparam int DELAY_DEPTH_DEF = 131072;
    localparam int COMB_COUNT_DEF  = 4;
    localparam int COMB_MAX        = 8;

    // q1.16 constants
    localparam logic [16:0] Q16_ONE      = 17'd65536;
    localparam logic [16:0] GAIN_03      = 17'd19661;
    localparam logic [16:0] GAIN_07      = 17'd45875;
    localparam logic [16:0] REVERB_FLOOR = 17'd655;

    // register map (word index)
    localparam logic [1:0] REG_DELAY_SAMPLES  = 2'd0;
    localparam logic [1:0] REG_DELAY_FEEDBACK = 2'd1;
    localparam logic [1:0] REG_REVERB_AMOUNT  = 2'd2;
    localparam logic [1:0] REG_WET_MIX        = 2'd3;

    // register reset values
    localparam logic [16:0] RST_DELAY_SAMPLES  = 17'd24000;
    localparam logic [16:0] RST_DELAY_FEEDBACK = 17'd32768;
    localparam logic [16:0] RST_REVERB_AMOUNT  = 17'd0;
    localparam logic [16:0] RST_WET_MIX        = 17'd32768;

    typedef logic [13:0] comb_addr_t;

    // comb lengths and start offsets in the shared comb memory
    localparam comb_addr_t COMB_LEN [COMB_MAX] = '{
        14'd1116, 14'd1188, 14'd1277, 14'd1356, 14'd1422, 14'd1491, 14'd1557, 14'd1617
    };
    localparam comb_addr_t COMB_BASE [COMB_MAX] = '{
        14'd0, 14'd1116, 14'd2304, 14'd3581, 14'd4937, 14'd6359, 14'd7850, 14'd9407
    };

    // total comb cells for a given comb count
    function automatic int comb_total(input int count);
        int total;
        total = 0;
        for (int i = 0; i < COMB_MAX; i++)
        begin
            if (i < count)
            begin
                total = total + int'(COMB_LEN[i]);
            end
        end
        return total;
    endfunction

    // saturate to a signed 24-bit sample
    function automatic logic [23:0] sat24(input logic signed [47:0] v);
        logic [23:0] r;
        if (v > 48'sd8388607)
        begin
            r = 24'h7FFFFF;
        end
        else if (v < -48'sd8388608)
        begin
            r = 24'h800000;
        end
        else
        begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/stereo_feedback_delay_comb_reverb_mix_core.sv =====
`default_nettype none

// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid / s_axis_tready   dry_left, dry_right, res_left, res_right
// m_axis    out  m_axis_tvalid / m_axis_tready   out_left, out_right
// apb       in   psel, penable, pwrite, pready   4 registers at byte address 4*i
//
// an item goes through the echo and mix steps, and with reverb on also the comb and
// lowpass steps; the comb pass reads and writes the comb memory once per comb
// the echo and comb memories need no clearing pass: a fill mark per store tells
// never-written cells, which read as zero, so items are taken right after reset
// a finished item waits in the output register; the next item is taken meanwhile,
// and the core holds in its last step only while that register is still full

module stereo_feedback_delay_comb_reverb_mix_core #(
    parameter int DELAY_DEPTH = sfdcr_pkg::DELAY_DEPTH_DEF,
    parameter int COMB_COUNT  = sfdcr_pkg::COMB_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // dry_left[23:0], dry_right[47:24], res_left[71:48], res_right[95:72]
    input  wire logic [95:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_left[23:0], out_right[47:24]
    output logic      [47:0] m_axis_tdata
);

    localparam int AW        = $clog2(DELAY_DEPTH);
    localparam int CW        = ((AW > 17) ? AW : 17) + 1;
    localparam int CMB_DEPTH = sfdcr_pkg::comb_total(COMB_COUNT);
    localparam int CAW       = $clog2(CMB_DEPTH);
    localparam int CIW       = (COMB_COUNT > 1) ? $clog2(COMB_COUNT) : 1;
    localparam int CIN       = 1 << CIW;

    localparam logic [CW-1:0]  DEPTH_C   = CW'(DELAY_DEPTH);
    localparam logic [AW-1:0]  LAST_POS  = AW'(DELAY_DEPTH - 1);
    localparam logic [CIW-1:0] LAST_COMB = CIW'(COMB_COUNT - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EMUL = 3'd1;
    localparam logic [2:0] S_EWR  = 3'd2;
    localparam logic [2:0] S_RVIN = 3'd3;
    localparam logic [2:0] S_COMB = 3'd4;
    localparam logic [2:0] S_LP   = 3'd5;
    localparam logic [2:0] S_MIX  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] state_reg, state_next;

    // configuration registers
    logic [16:0] delay_samples_reg, delay_feedback_reg, reverb_amount_reg, wet_mix_reg;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_samples_reg  <= sfdcr_pkg::RST_DELAY_SAMPLES;
            delay_feedback_reg <= sfdcr_pkg::RST_DELAY_FEEDBACK;
            reverb_amount_reg  <= sfdcr_pkg::RST_REVERB_AMOUNT;
            wet_mix_reg        <= sfdcr_pkg::RST_WET_MIX;
        end
        else if (cfg_we)
        begin
            unique case (paddr[3:2])
                sfdcr_pkg::REG_DELAY_SAMPLES:  delay_samples_reg  <= pwdata[16:0];
                sfdcr_pkg::REG_DELAY_FEEDBACK: delay_feedback_reg <= pwdata[16:0];
                sfdcr_pkg::REG_REVERB_AMOUNT:  reverb_amount_reg  <= pwdata[16:0];
                sfdcr_pkg::REG_WET_MIX:        wet_mix_reg        <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[3:2])
            sfdcr_pkg::REG_DELAY_SAMPLES:  prdata = {15'd0, delay_samples_reg};
            sfdcr_pkg::REG_DELAY_FEEDBACK: prdata = {15'd0, delay_feedback_reg};
            sfdcr_pkg::REG_REVERB_AMOUNT:  prdata = {15'd0, reverb_amount_reg};
            sfdcr_pkg::REG_WET_MIX:        prdata = {15'd0, wet_mix_reg};
            default:                       prdata = 32'd0;
        endcase
    end

    // gains limited to one
    logic [16:0] fb, amt, mix;
    assign fb  = (delay_feedback_reg > sfdcr_pkg::Q16_ONE) ? sfdcr_pkg::Q16_ONE
                                                           : delay_feedback_reg;
    assign amt = (reverb_amount_reg > sfdcr_pkg::Q16_ONE) ? sfdcr_pkg::Q16_ONE
                                                          : reverb_amount_reg;
    assign mix = (wet_mix_reg > sfdcr_pkg::Q16_ONE) ? sfdcr_pkg::Q16_ONE : wet_mix_reg;

    logic signed [17:0] fb_s, fb_inv_s, mix_s, mix_inv_s;
    assign fb_s      = $signed({1'b0, fb});
    assign fb_inv_s  = $signed({1'b0, sfdcr_pkg::Q16_ONE - fb});
    assign mix_s     = $signed({1'b0, mix});
    assign mix_inv_s = $signed({1'b0, sfdcr_pkg::Q16_ONE - mix});

    logic in_fire, out_load, reverb_on;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == S_DONE) && (!m_axis_tvalid || m_axis_tready);
    assign reverb_on     = (reverb_amount_reg > sfdcr_pkg::REVERB_FLOOR);

    // input item
    logic signed [23:0] dry_l_reg, dry_r_reg, res_l_reg, res_r_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            dry_l_reg <= s_axis_tdata[23:0];
            dry_r_reg <= s_axis_tdata[47:24];
            res_l_reg <= s_axis_tdata[71:48];
            res_r_reg <= s_axis_tdata[95:72];
        end
    end

    // echo addressing, fill mark tells cells not yet written since reset
    logic [AW-1:0] wp_reg;
    logic          echo_wrapped_reg;
    logic [CW-1:0] d_ext, wp_ext, rp_ext;
    logic [AW-1:0] rp;
    logic          echo_valid_reg;

    assign d_ext  = (CW'(delay_samples_reg) >= DEPTH_C) ? DEPTH_C - CW'(1)
                                                        : CW'(delay_samples_reg);
    assign wp_ext = CW'(wp_reg);
    assign rp_ext = (wp_ext >= d_ext) ? wp_ext - d_ext : wp_ext + DEPTH_C - d_ext;
    assign rp     = rp_ext[AW-1:0];

    // echo memory, left in the low half
    logic [47:0] echo_mem [DELAY_DEPTH];
    logic [47:0] echo_rdata_reg;
    logic [47:0] echo_wdata;
    logic        echo_we;

    always_ff @(posedge clk)
    begin
        if (echo_we)
        begin
            echo_mem[wp_reg] <= echo_wdata;
        end
        if (in_fire)
        begin
            echo_rdata_reg <= echo_mem[rp];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg           <= '0;
            echo_wrapped_reg <= 1'b0;
            echo_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                echo_valid_reg <= echo_wrapped_reg || (rp < wp_reg);
            end
            if (echo_we)
            begin
                if (wp_reg == LAST_POS)
                begin
                    wp_reg           <= '0;
                    echo_wrapped_reg <= 1'b1;
                end
                else
                begin
                    wp_reg <= wp_reg + AW'(1);
                end
            end
        end
    end

    // echo products
    logic signed [23:0] dl_l, dl_r;
    logic signed [41:0] p_dl_l_reg, p_dl_r_reg, p_x_l_reg, p_x_r_reg;
    logic        [31:0] rv_prod_reg;

    assign dl_l = echo_valid_reg ? $signed(echo_rdata_reg[23:0]) : 24'sd0;
    assign dl_r = echo_valid_reg ? $signed(echo_rdata_reg[47:24]) : 24'sd0;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EMUL)
        begin
            p_dl_l_reg  <= 42'(dl_l * fb_s);
            p_dl_r_reg  <= 42'(dl_r * fb_s);
            p_x_l_reg   <= 42'(res_l_reg * fb_inv_s);
            p_x_r_reg   <= 42'(res_r_reg * fb_inv_s);
            rv_prod_reg <= 32'(amt * sfdcr_pkg::GAIN_03);
        end
    end

    // echo write back and wet signal
    logic signed [41:0] e_sum_l, e_sum_r, e_fb_l, e_fb_r;
    logic signed [26:0] wl_reg, wr_reg;
    logic        [15:0] rv_reg;
    logic        [31:0] rv_rnd;

    assign e_sum_l = p_dl_l_reg + p_x_l_reg + 42'sd32768;
    assign e_sum_r = p_dl_r_reg + p_x_r_reg + 42'sd32768;
    assign e_fb_l  = p_dl_l_reg + 42'sd32768;
    assign e_fb_r  = p_dl_r_reg + 42'sd32768;
    assign rv_rnd  = rv_prod_reg + 32'd32768;

    assign echo_we    = (state_reg == S_EWR);
    assign echo_wdata = {
        sfdcr_pkg::sat24(48'(res_r_reg) + 48'($signed(e_fb_r[41:16]))),
        sfdcr_pkg::sat24(48'(res_l_reg) + 48'($signed(e_fb_l[41:16])))
    };

    // comb pass bookkeeping
    logic [CIW-1:0] cidx_reg;
    logic [CIW-1:0] issue_idx;
    logic           comb_rd;
    logic [10:0]    pos_reg [CIN];
    logic           comb_wrapped_reg [CIN];
    logic [10:0]    pos_cur;
    logic [13:0]    len_cur;
    logic [13:0]    addr_full;
    logic [CAW-1:0] comb_addr_reg;
    logic           comb_valid_reg;
    logic           pos_last;

    assign issue_idx = (state_reg == S_RVIN) ? '0 : cidx_reg + CIW'(1);
    assign comb_rd   = (state_reg == S_RVIN) || ((state_reg == S_COMB) && (cidx_reg != LAST_COMB));
    assign pos_cur   = pos_reg[issue_idx];
    assign len_cur   = sfdcr_pkg::COMB_LEN[3'(issue_idx)];
    assign addr_full = sfdcr_pkg::COMB_BASE[3'(issue_idx)] + 14'(pos_cur);
    assign pos_last  = (14'(pos_cur) + 14'd1 == len_cur);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CIN; i++)
            begin
                pos_reg[i]          <= '0;
                comb_wrapped_reg[i] <= 1'b0;
            end
            comb_valid_reg <= 1'b0;
            cidx_reg       <= '0;
        end
        else
        begin
            if (comb_rd)
            begin
                comb_valid_reg <= comb_wrapped_reg[issue_idx];
                cidx_reg       <= issue_idx;
                if (pos_last)
                begin
                    pos_reg[issue_idx]          <= '0;
                    comb_wrapped_reg[issue_idx] <= 1'b1;
                end
                else
                begin
                    pos_reg[issue_idx] <= pos_cur + 11'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (comb_rd)
        begin
            comb_addr_reg <= addr_full[CAW-1:0];
        end
    end

    // comb memory, left in the low half
    logic [47:0] comb_mem [CMB_DEPTH];
    logic [47:0] comb_rdata_reg;
    logic [47:0] comb_wdata;
    logic        comb_we;

    always_ff @(posedge clk)
    begin
        if (comb_we)
        begin
            comb_mem[comb_addr_reg] <= comb_wdata;
        end
        if (comb_rd)
        begin
            comb_rdata_reg <= comb_mem[addr_full[CAW-1:0]];
        end
    end

    // comb cell update: in + cell/2 rounded
    logic signed [41:0] in_prod_l_reg, in_prod_r_reg, in_rnd_l, in_rnd_r;
    logic signed [23:0] cell_l, cell_r;
    logic signed [24:0] half_l, half_r;
    logic        [23:0] new_l, new_r;
    logic signed [26:0] sum_l_reg, sum_r_reg;

    assign comb_we  = (state_reg == S_COMB);
    assign in_rnd_l = in_prod_l_reg + 42'sd32768;
    assign in_rnd_r = in_prod_r_reg + 42'sd32768;
    assign cell_l   = comb_valid_reg ? $signed(comb_rdata_reg[23:0]) : 24'sd0;
    assign cell_r   = comb_valid_reg ? $signed(comb_rdata_reg[47:24]) : 24'sd0;
    assign half_l   = 25'(cell_l) + 25'sd1;
    assign half_r   = 25'(cell_r) + 25'sd1;
    assign new_l    = sfdcr_pkg::sat24(48'($signed(in_rnd_l[41:16]))
                                       + 48'($signed(half_l[24:1])));
    assign new_r    = sfdcr_pkg::sat24(48'($signed(in_rnd_r[41:16]))
                                       + 48'($signed(half_r[24:1])));
    assign comb_wdata = {new_r, new_l};

    // lowpass and mix
    logic signed [23:0] smooth_l_reg, smooth_r_reg;
    logic signed [43:0] lp_sum_l_reg, lp_sum_r_reg, lp_rnd_l, lp_rnd_r;
    logic        [23:0] lp_l, lp_r;
    logic signed [45:0] mix_l_reg, mix_r_reg, mix_rnd_l, mix_rnd_r;
    logic signed [16:0] g07_s;
    logic signed [16:0] g03_s;

    assign g07_s     = $signed(sfdcr_pkg::GAIN_07);
    assign g03_s     = $signed(sfdcr_pkg::GAIN_03);
    assign lp_rnd_l  = lp_sum_l_reg + 44'sd32768;
    assign lp_rnd_r  = lp_sum_r_reg + 44'sd32768;
    assign lp_l      = sfdcr_pkg::sat24(48'($signed(lp_rnd_l[43:16])));
    assign lp_r      = sfdcr_pkg::sat24(48'($signed(lp_rnd_r[43:16])));
    assign mix_rnd_l = mix_l_reg + 46'sd32768;
    assign mix_rnd_r = mix_r_reg + 46'sd32768;

    // lowpass state, updated once the lowpass sum is ready
    logic lp_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_l_reg <= '0;
            smooth_r_reg <= '0;
            lp_done_reg  <= 1'b0;
        end
        else
        begin
            lp_done_reg <= (state_reg == S_LP);
            if (lp_done_reg)
            begin
                smooth_l_reg <= lp_l;
                smooth_r_reg <= lp_r;
            end
        end
    end

    // wet signal with reverb added, taken in the mix step after the lowpass
    logic signed [26:0] wl_mix, wr_mix;
    assign wl_mix = lp_done_reg ? wl_reg + 27'($signed(lp_l)) : wl_reg;
    assign wr_mix = lp_done_reg ? wr_reg + 27'($signed(lp_r)) : wr_reg;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_EWR:
            begin
                wl_reg <= 27'($signed(e_sum_l[41:16]));
                wr_reg <= 27'($signed(e_sum_r[41:16]));
                rv_reg <= rv_rnd[31:16];
            end
            S_RVIN:
            begin
                in_prod_l_reg <= 42'(wl_reg * $signed({1'b0, rv_reg}));
                in_prod_r_reg <= 42'(wr_reg * $signed({1'b0, rv_reg}));
                sum_l_reg     <= '0;
                sum_r_reg     <= '0;
            end
            S_COMB:
            begin
                sum_l_reg <= sum_l_reg + 27'($signed(new_l));
                sum_r_reg <= sum_r_reg + 27'($signed(new_r));
            end
            S_LP:
            begin
                lp_sum_l_reg <= 44'(smooth_l_reg * g07_s) + 44'(sum_l_reg * g03_s);
                lp_sum_r_reg <= 44'(smooth_r_reg * g07_s) + 44'(sum_r_reg * g03_s);
            end
            S_MIX:
            begin
                if (lp_done_reg)
                begin
                    wl_reg <= wl_mix;
                    wr_reg <= wr_mix;
                end
                mix_l_reg <= 46'(dry_l_reg * mix_inv_s) + 46'(wl_reg * mix_s);
                mix_r_reg <= 46'(dry_r_reg * mix_inv_s) + 46'(wr_reg * mix_s);
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_fire) state_next = S_EMUL;
            S_EMUL: state_next = S_EWR;
            S_EWR:  state_next = reverb_on ? S_RVIN : S_MIX;
            S_RVIN: state_next = S_COMB;
            S_COMB: if (cidx_reg == LAST_COMB) state_next = S_LP;
            S_LP:   state_next = S_MIX;
            S_MIX:  state_next = lp_done_reg ? S_MIX : S_DONE;
            S_DONE: if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // output register
    logic        m_valid_reg;
    logic [47:0] m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= {sfdcr_pkg::sat24(48'($signed(mix_rnd_r[45:16]))),
                           sfdcr_pkg::sat24(48'($signed(mix_rnd_l[45:16])))};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // checks
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_EMUL))
        else $error("item accepted but echo step did not follow");

    a_comb_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMB) |-> (cidx_reg <= LAST_COMB))
        else $error("comb index beyond comb count");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result shown without finishing an item");

    a_echo_once: assert property (@(posedge clk) disable iff (!rst_n)
        echo_we |=> !echo_we)
        else $error("echo cell written twice for one item");

endmodule

`default_nettype wire

// ===== test/checker.sv =====
`timescale 1ns / 1ps

module mix_checker #(
    parameter int DELAY_DEPTH = sfdcr_pkg::DELAY_DEPTH_DEF,
    parameter int COMB_COUNT  = sfdcr_pkg::COMB_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [47:0] m_axis_tdata,
    output int               fail_count,
    output int               pending
);

    localparam int COMB_CELLS = 11024;

    // predictor state
    logic [16:0] delay_reg, fb_reg, amount_reg, mix_reg;
    logic signed [23:0] echo_l [DELAY_DEPTH];
    logic signed [23:0] echo_r [DELAY_DEPTH];
    int unsigned echo_wp;
    logic signed [23:0] comb_l [COMB_CELLS];
    logic signed [23:0] comb_r [COMB_CELLS];
    int unsigned comb_pos [2][sfdcr_pkg::COMB_MAX];
    logic signed [23:0] smooth_l, smooth_r;
    logic [47:0] expected_frames [$];

    function automatic longint round16(input longint x);
        return (x + 32768) >>> 16;
    endfunction

    function automatic longint clip24(input longint x);
        if (x > 8388607) return 8388607;
        if (x < -8388608) return -8388608;
        return x;
    endfunction

    function automatic longint clamp_gain(input logic [16:0] g);
        return (g > sfdcr_pkg::Q16_ONE) ? 65536 : longint'(g);
    endfunction

    function automatic longint sext(input logic [23:0] v);
        return longint'(signed'(v));
    endfunction

    // one channel's comb bank and lowpass
    task automatic run_combs(input int ch, input longint wet, input longint send,
                             output longint res);
        longint sum, drive, tap, lp;
        int unsigned p, idx;
        sum = 0;
        drive = round16(wet * send);
        for (int c = 0; c < COMB_COUNT && c < sfdcr_pkg::COMB_MAX; c++)
        begin
            p = (comb_pos[ch][c] < sfdcr_pkg::COMB_LEN[c]) ? comb_pos[ch][c] : 0;
            idx = sfdcr_pkg::COMB_BASE[c] + p;
            tap = (ch == 0) ? sext(comb_l[idx]) : sext(comb_r[idx]);
            tap = clip24(drive + round16(tap * 32768));
            if (ch == 0) comb_l[idx] = tap[23:0]; else comb_r[idx] = tap[23:0];
            sum += tap;
            comb_pos[ch][c] = (p + 1 == sfdcr_pkg::COMB_LEN[c]) ? 0 : p + 1;
        end
        lp = (ch == 0) ? sext(smooth_l) : sext(smooth_r);
        lp = clip24(round16(lp * 45875 + sum * 19661));
        if (ch == 0) smooth_l = lp[23:0]; else smooth_r = lp[23:0];
        res = wet + lp;
    endtask

    // work out the mixed frame for one input item
    task automatic predict_frame(input logic [95:0] d);
        longint dry_l, dry_r, in_l, in_r, fb, amt, mix, dl, dr, wl, wr, send, o_l, o_r;
        int unsigned dly, wp, rp;
        dry_l = sext(d[23:0]);
        dry_r = sext(d[47:24]);
        in_l = sext(d[71:48]);
        in_r = sext(d[95:72]);
        fb = clamp_gain(fb_reg);
        amt = clamp_gain(amount_reg);
        mix = clamp_gain(mix_reg);
        dly = (delay_reg >= DELAY_DEPTH) ? DELAY_DEPTH - 1 : delay_reg;
        wp = echo_wp % DELAY_DEPTH;
        rp = (wp + DELAY_DEPTH - dly) % DELAY_DEPTH;
        dl = sext(echo_l[rp]);
        dr = sext(echo_r[rp]);
        echo_l[wp] = 24'(clip24(in_l + round16(dl * fb)));
        echo_r[wp] = 24'(clip24(in_r + round16(dr * fb)));
        wl = round16(in_l * (65536 - fb) + dl * fb);
        wr = round16(in_r * (65536 - fb) + dr * fb);
        echo_wp = (wp + 1) % DELAY_DEPTH;
        if (amt > 655)
        begin
            send = round16(amt * 19661);
            run_combs(0, wl, send, wl);
            run_combs(1, wr, send, wr);
        end
        o_l = clip24(round16(dry_l * (65536 - mix) + wl * mix));
        o_r = clip24(round16(dry_r * (65536 - mix) + wr * mix));
        expected_frames.push_back({o_r[23:0], o_l[23:0]});
    endtask

    task automatic report(input string what);
        $display("mismatch: %s", what);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [47:0] want;
        if (!rst_n)
        begin
            delay_reg = sfdcr_pkg::RST_DELAY_SAMPLES;
            fb_reg = sfdcr_pkg::RST_DELAY_FEEDBACK;
            amount_reg = sfdcr_pkg::RST_REVERB_AMOUNT;
            mix_reg = sfdcr_pkg::RST_WET_MIX;
            for (int i = 0; i < DELAY_DEPTH; i++)
            begin
                echo_l[i] = '0;
                echo_r[i] = '0;
            end
            for (int i = 0; i < COMB_CELLS; i++)
            begin
                comb_l[i] = '0;
                comb_r[i] = '0;
            end
            for (int i = 0; i < sfdcr_pkg::COMB_MAX; i++)
            begin
                comb_pos[0][i] = 0;
                comb_pos[1][i] = 0;
            end
            echo_wp = 0;
            smooth_l = '0;
            smooth_r = '0;
            fail_count = 0;
            expected_frames.delete();
            pending = 0;
        end
        else
        begin
            // register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    sfdcr_pkg::REG_DELAY_SAMPLES:  delay_reg = pwdata[16:0];
                    sfdcr_pkg::REG_DELAY_FEEDBACK: fb_reg = pwdata[16:0];
                    sfdcr_pkg::REG_REVERB_AMOUNT:  amount_reg = pwdata[16:0];
                    sfdcr_pkg::REG_WET_MIX:        mix_reg = pwdata[16:0];
                    default: ;
                endcase
            end
            // output item compare
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_frames.size() == 0)
                begin
                    report("output item with no expectation");
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (m_axis_tdata[23:0] !== want[23:0])
                        report($sformatf("out_left got %h want %h",
                                         m_axis_tdata[23:0], want[23:0]));
                    if (m_axis_tdata[47:24] !== want[47:24])
                        report($sformatf("out_right got %h want %h",
                                         m_axis_tdata[47:24], want[47:24]));
                end
            end
            // input item prediction
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_frame(s_axis_tdata);
            end
            pending = expected_frames.size();
        end
    end
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1500;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          quiet_cycles;

    stereo_feedback_delay_comb_reverb_mix_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    mix_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // receiver stalls
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on accepted traffic
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [16:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {15'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // valid stays high after the item so the next one can follow at once
    task automatic send_frame(input logic [23:0] dl, input logic [23:0] dr,
                              input logic [23:0] rl, input logic [23:0] rr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {rr, rl, dr, dl};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
    endtask

    // random sample, often near the rails
    function automatic logic [23:0] rand_sample();
        case ($urandom_range(5))
            0: return 24'h7FFFFF - 24'($urandom_range(15));
            1: return 24'h800000 + 24'($urandom_range(15));
            2: return 24'($urandom_range(4095)) - 24'd2048;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [16:0] rand_gain();
        case ($urandom_range(5))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'h1FFFF - 17'($urandom_range(65535));
            3: return 17'd655 + 17'($urandom_range(1));
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    // drop valid and wait for every item to come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic random_phase(input int count);
        logic [16:0] dly;
        dly = $urandom_range(3) == 0 ? 17'h1FFFF - 17'($urandom_range(1000))
                                     : 17'($urandom_range(64));
        wait_drained();
        reg_write(sfdcr_pkg::REG_DELAY_SAMPLES, dly);
        reg_write(sfdcr_pkg::REG_DELAY_FEEDBACK, rand_gain());
        reg_write(sfdcr_pkg::REG_REVERB_AMOUNT,
                  $urandom_range(1) ? 17'd65536 : rand_gain());
        reg_write(sfdcr_pkg::REG_WET_MIX, rand_gain());
        for (int i = 0; i < count; i++)
            send_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample());
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        send_idle_pct = 13;
        recv_idle_pct = 84;
        quiet_cycles = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, rails and zero
        send_frame(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000);
        send_frame(24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        send_frame(24'h000000, 24'hFFFFFF, 24'h000001, 24'hFFFFFF);
        // zero delay wraps around the whole ring, short delay, full feedback
        wait_drained();
        reg_write(sfdcr_pkg::REG_DELAY_SAMPLES, 17'd0);
        reg_write(sfdcr_pkg::REG_DELAY_FEEDBACK, 17'h1FFFF);
        reg_write(sfdcr_pkg::REG_WET_MIX, 17'd65536);
        reg_write(sfdcr_pkg::REG_REVERB_AMOUNT, 17'd655);
        for (int i = 0; i < 4; i++)
            send_frame(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000);
        wait_drained();
        reg_write(sfdcr_pkg::REG_DELAY_SAMPLES, 17'd1);
        reg_write(sfdcr_pkg::REG_REVERB_AMOUNT, 17'd656);
        for (int i = 0; i < 6; i++)
            send_frame(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF);
        // longest delay the ring holds, reverb at full send above one, dry only
        wait_drained();
        reg_write(sfdcr_pkg::REG_DELAY_SAMPLES, 17'h1FFFF);
        reg_write(sfdcr_pkg::REG_REVERB_AMOUNT, 17'h1FFFF);
        reg_write(sfdcr_pkg::REG_WET_MIX, 17'd0);
        reg_write(sfdcr_pkg::REG_DELAY_FEEDBACK, 17'd0);
        for (int i = 0; i < 4; i++)
            send_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample());
        wait_drained();
        reg_write(sfdcr_pkg::REG_WET_MIX, 17'h1FFFF);
        for (int i = 0; i < 4; i++)
            send_frame(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);

        // random phases across idling profiles
        for (int ph = 0; ph < 15; ph++)
        begin
            if (ph == 5)
            begin
                send_idle_pct = 84;
                recv_idle_pct = 13;
            end
            else if (ph == 10)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_phase(RANDOM_ITEMS / 15);
        end

        wait_drained();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
